@@ src/tsdf_pkg.sv @@
// Shared types and constants for the TSDF ray integrator.
// Used by the top level and by the shared divider; depends on nothing.
package tsdf_pkg;

    localparam int DIV_NUM_W = 48;   // signed dividend width
    localparam int DIV_DEN_W = 24;   // positive divisor width
    localparam int STORE_AW  = 18;   // voxel store address width

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] num;
        logic        [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic signed [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

@@ src/tsdf_div.sv @@
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on tsdf_pkg for its request and response structs.
module tsdf_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  tsdf_pkg::div_req_t req,
    output tsdf_pkg::div_rsp_t rsp
);
    import tsdf_pkg::*;

    localparam int MAG_W = DIV_NUM_W - 1;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [MAG_W-1:0]     quo_reg, quo_next;

    logic [DIV_DEN_W:0]   rem_shift;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;
    logic [MAG_W-1:0]     num_mag;

    assign num_mag   = req.num[DIV_NUM_W-1] ? MAG_W'(-req.num) : MAG_W'(req.num);
    assign rem_shift = {rem_reg, quo_reg[MAG_W-1]};
    assign ge        = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            neg_next  = req.num[DIV_NUM_W-1];
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = num_mag;
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
            quo_next = {quo_reg[MAG_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

@@ src/tsdf_ray_integrator.sv @@
// TSDF ray integrator top level: sequencer, shared multiplier, voxel store.
// Depends on tsdf_pkg and on the shared divider tsdf_div.
//
//  channel  direction  contents
//  s_       in         tuser: kind; tdata: point xyz, camera xyz, voxel_index
//  m_       out        tdata: distance_value, weight_value, voxels_updated, ray_cut
//  cfg_     in         register writes, index 0 voxel_size, index 1 truncation_distance
//
// After reset the voxel store is cleared one entry per cycle, all 262144 entries, and no item is taken until then.
// A read item passes through ST_RD and ST_RD2 to ST_DONE. An integrate item first sets up (squares and a
// 22-step square root), then works each sample, outside or inside the grid, on the shared 47-step
// divider (six or eight divisions per sample, three or five on a zero-length ray).
// One item is worked on at a time; a finished result waits in the output register, and a
// stalled output only holds the sequencer when the next result is ready.
module tsdf_ray_integrator #(
    parameter int GRID_X    = 64,
    parameter int GRID_Y    = 64,
    parameter int GRID_Z    = 64,
    parameter int MAX_STEPS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [19:0] point_x, [39:20] point_y, [59:40] point_z, [79:60] camera_x,
    // [99:80] camera_y, [119:100] camera_z, [137:120] voxel_index
    input  logic [143:0] s_tdata,
    // [0] kind
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] distance_value, [31:16] weight_value, [42:32] voxels_updated, [43] ray_cut
    output logic [47:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);
    import tsdf_pkg::*;

    localparam int K_W   = $clog2(MAX_STEPS + 1);
    localparam int IDX_W = 27;
    localparam int POS_W = 26;
    localparam int SQ_W  = 44;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_RD     = 4'd2;
    localparam logic [3:0] ST_RD2    = 4'd3;
    localparam logic [3:0] ST_SQ     = 4'd4;
    localparam logic [3:0] ST_SQRT   = 4'd5;
    localparam logic [3:0] ST_CHECK  = 4'd6;
    localparam logic [3:0] ST_MUL    = 4'd7;
    localparam logic [3:0] ST_DSTART = 4'd8;
    localparam logic [3:0] ST_DWAIT  = 4'd9;
    localparam logic [3:0] ST_GRID   = 4'd10;
    localparam logic [3:0] ST_ADDR   = 4'd11;
    localparam logic [3:0] ST_WMUL   = 4'd12;
    localparam logic [3:0] ST_NEXT   = 4'd13;
    localparam logic [3:0] ST_DONE   = 4'd14;

    localparam logic [1:0] OP_POS = 2'd0;
    localparam logic [1:0] OP_IDX = 2'd1;
    localparam logic [1:0] OP_SDF = 2'd2;
    localparam logic [1:0] OP_AVG = 2'd3;

    localparam logic [0:0] REG_VOXEL_SIZE = 1'b0;
    localparam logic [0:0] REG_TRUNC      = 1'b1;

    logic [3:0]                state_reg, state_next;
    logic [1:0]                axis_reg, axis_next;
    logic [1:0]                op_reg, op_next;
    logic [STORE_AW-1:0]       clr_reg, clr_next;
    logic [STORE_AW-1:0]       addr_reg, addr_next;
    logic [15:0]               vs_reg, tr_reg;
    logic signed [19:0]        c_reg [3], c_next [3];
    logic signed [20:0]        d_reg [3], d_next [3];
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic [SQ_W-1:0]           n_reg, n_next;
    logic [SQ_W-1:0]           root_reg, root_next;
    logic [SQ_W-1:0]           bit_reg, bit_next;
    logic signed [46:0]        mul_reg, mul_next;
    logic [20:0]               dist_reg, dist_next;
    logic [23:0]               limit2_reg, limit2_next;
    logic [23:0]               t2_reg, t2_next;
    logic [K_W-1:0]            k_reg, k_next;
    logic signed [POS_W-1:0]   pos_reg [3], pos_next [3];
    logic signed [IDX_W-1:0]   idx_reg [3], idx_next [3];
    logic signed [17:0]        sdf_reg, sdf_next;
    logic signed [15:0]        s_reg, s_next;
    logic [10:0]               cnt_reg, cnt_next;
    logic                      cut_reg, cut_next;
    logic [15:0]               res_dist_reg, res_dist_next;
    logic [15:0]               res_w_reg, res_w_next;
    logic                      m_valid_reg, m_valid_next;
    logic [47:0]               m_data_reg, m_data_next;
    logic [31:0]               rd_data_reg;

    logic [31:0]               store [2**STORE_AW];
    logic                      mem_we;
    logic [STORE_AW-1:0]       mem_wa;
    logic [31:0]               mem_wd;

    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    logic [15:0]               vs_eff, tr_eff;
    logic [1:0]                axis_idx;
    logic [20:0]               mag;
    logic signed [24:0]        mul_a;
    logic signed [21:0]        mul_b;
    logic signed [46:0]        mul_p;
    logic [SQ_W-1:0]           trial;
    logic [SQ_W-1:0]           root_upd;
    logic signed [24:0]        sdf_raw;
    logic signed [18:0]        tr2;
    logic                      in_grid;
    logic signed [15:0]        old_dist;
    logic [15:0]               old_w;
    logic                      accept;

    tsdf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign vs_eff   = (vs_reg == 16'd0) ? 16'd1 : vs_reg;
    assign tr_eff   = (tr_reg == 16'd0) ? 16'd1 : tr_reg;
    assign axis_idx = (axis_reg == 2'd3) ? 2'd0 : axis_reg;
    assign mag      = d_reg[axis_idx][20] ? 21'(-d_reg[axis_idx]) : 21'(d_reg[axis_idx]);
    assign old_dist = $signed(rd_data_reg[31:16]);
    assign old_w    = rd_data_reg[15:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign trial    = root_reg + bit_reg;
    assign tr2      = $signed({2'b00, tr_eff, 1'b0});
    assign sdf_raw  = $signed({3'b000, dist_reg, 1'b0}) - $signed({1'b0, t2_reg});
    assign in_grid  = !idx_reg[0][IDX_W-1] && !idx_reg[1][IDX_W-1] && !idx_reg[2][IDX_W-1]
                   && (idx_reg[0] < $signed(IDX_W'(GRID_X)))
                   && (idx_reg[1] < $signed(IDX_W'(GRID_Y)))
                   && (idx_reg[2] < $signed(IDX_W'(GRID_Z)));

    // One multiplier serves the squares, the ray offsets and the weighted sum.
    always_comb begin
        unique case (state_reg)
            ST_MUL: begin
                mul_a = $signed({1'b0, t2_reg});
                mul_b = 22'(d_reg[axis_idx]);
            end
            ST_WMUL: begin
                mul_a = $signed({9'd0, old_w});
                mul_b = 22'(old_dist);
            end
            default: begin
                mul_a = $signed({4'd0, mag});
                mul_b = $signed({1'b0, mag});
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        div_req.start = (state_reg == ST_DSTART);
        unique case (op_reg)
            OP_POS: begin
                div_req.num = DIV_NUM_W'(mul_reg);
                div_req.den = DIV_DEN_W'({dist_reg, 1'b0});
            end
            OP_IDX: begin
                div_req.num = DIV_NUM_W'(pos_reg[axis_idx]);
                div_req.den = DIV_DEN_W'(vs_eff);
            end
            OP_SDF: begin
                div_req.num = DIV_NUM_W'($signed({sdf_reg, 13'd0}));
                div_req.den = DIV_DEN_W'(tr_eff);
            end
            default: begin
                div_req.num = DIV_NUM_W'(mul_reg) + DIV_NUM_W'(s_reg);
                div_req.den = DIV_DEN_W'({1'b0, old_w} + 17'd1);
            end
        endcase
    end

    always_comb begin
        root_upd = (n_reg >= trial) ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    end

    always_comb begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        op_next       = op_reg;
        clr_next      = clr_reg;
        addr_next     = addr_reg;
        c_next        = c_reg;
        d_next        = d_reg;
        sq_next       = sq_reg;
        n_next        = n_reg;
        root_next     = root_reg;
        bit_next      = bit_reg;
        mul_next      = mul_reg;
        dist_next     = dist_reg;
        limit2_next   = limit2_reg;
        t2_next       = t2_reg;
        k_next        = k_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        sdf_next      = sdf_reg;
        s_next        = s_reg;
        cnt_next      = cnt_reg;
        cut_next      = cut_reg;
        res_dist_next = res_dist_reg;
        res_w_next    = res_w_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_wa        = addr_reg;
        mem_wd        = {div_rsp.quo[15:0], (old_w == 16'hFFFF) ? old_w : old_w + 16'd1};

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                mem_wd   = {16'h4000, 16'h0000};
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    for (int a = 0; a < 3; a++) begin
                        c_next[a] = $signed(s_tdata[60 + 20*a +: 20]);
                        d_next[a] = 21'($signed(s_tdata[20*a +: 20]))
                                  - 21'($signed(s_tdata[60 + 20*a +: 20]));
                    end
                    addr_next     = s_tdata[120 +: STORE_AW];
                    sq_next       = '0;
                    axis_next     = 2'd0;
                    res_dist_next = '0;
                    res_w_next    = '0;
                    cnt_next      = '0;
                    cut_next      = 1'b0;
                    state_next    = s_tuser[0] ? ST_RD : ST_SQ;
                end
            end
            ST_RD: begin
                state_next = ST_RD2;
            end
            ST_RD2: begin
                res_dist_next = rd_data_reg[31:16];
                res_w_next    = rd_data_reg[15:0];
                state_next    = ST_DONE;
            end
            ST_SQ: begin
                mul_next = mul_p;
                if (axis_reg != 2'd0) begin
                    sq_next = sq_reg + SQ_W'(mul_reg);
                end
                if (axis_reg == 2'd3) begin
                    n_next     = sq_reg + SQ_W'(mul_reg);
                    root_next  = '0;
                    bit_next   = SQ_W'(1) << (SQ_W - 2);
                    state_next = ST_SQRT;
                end else begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_SQRT: begin
                if (n_reg >= trial) begin
                    n_next = n_reg - trial;
                end
                root_next = root_upd;
                bit_next  = bit_reg >> 2;
                if (bit_reg == SQ_W'(1)) begin
                    dist_next   = root_upd[20:0];
                    limit2_next = 24'({root_upd[20:0], 1'b0}) + 24'({tr_eff, 1'b0});
                    t2_next     = '0;
                    k_next      = '0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                axis_next = 2'd0;
                priority if (t2_reg >= limit2_reg) begin
                    state_next = ST_DONE;
                end else if (k_reg >= K_W'(MAX_STEPS)) begin
                    cut_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (dist_reg == 21'd0) begin
                    // Zero-length ray: every sample sits at the camera.
                    for (int a = 0; a < 3; a++) begin
                        pos_next[a] = POS_W'(c_reg[a]);
                    end
                    op_next    = OP_IDX;
                    state_next = ST_DSTART;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                mul_next   = mul_p;
                op_next    = OP_POS;
                state_next = ST_DSTART;
            end
            ST_DSTART: begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_rsp.done) begin
                    unique case (op_reg)
                        OP_POS: begin
                            pos_next[axis_idx] = POS_W'(c_reg[axis_idx])
                                               + div_rsp.quo[POS_W-1:0];
                            if (axis_reg == 2'd2) begin
                                axis_next  = 2'd0;
                                op_next    = OP_IDX;
                                state_next = ST_DSTART;
                            end else begin
                                axis_next  = axis_reg + 2'd1;
                                state_next = ST_MUL;
                            end
                        end
                        OP_IDX: begin
                            unique case (axis_idx)
                                2'd0: idx_next[0] = div_rsp.quo[IDX_W-1:0]
                                                  + IDX_W'(GRID_X / 2);
                                2'd1: idx_next[1] = div_rsp.quo[IDX_W-1:0]
                                                  + IDX_W'(GRID_Y / 2);
                                default: idx_next[2] = div_rsp.quo[IDX_W-1:0];
                            endcase
                            if (axis_reg == 2'd2) begin
                                state_next = ST_GRID;
                            end else begin
                                axis_next  = axis_reg + 2'd1;
                                state_next = ST_DSTART;
                            end
                        end
                        OP_SDF: begin
                            s_next     = div_rsp.quo[15:0];
                            state_next = ST_WMUL;
                        end
                        default: begin
                            mem_we     = 1'b1;
                            cnt_next   = (cnt_reg == 11'h7FF) ? cnt_reg : cnt_reg + 11'd1;
                            state_next = ST_NEXT;
                        end
                    endcase
                end
            end
            ST_GRID: begin
                if (!in_grid) begin
                    state_next = ST_NEXT;
                end else begin
                    addr_next = idx_reg[1][STORE_AW-1:0]
                              + STORE_AW'(STORE_AW'(GRID_Y) * idx_reg[2][STORE_AW-1:0]);
                    priority if (sdf_raw > 25'(tr2)) begin
                        sdf_next = 18'(tr2);
                    end else if (sdf_raw < -25'(tr2)) begin
                        sdf_next = 18'(-tr2);
                    end else begin
                        sdf_next = 18'(sdf_raw);
                    end
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                addr_next  = idx_reg[0][STORE_AW-1:0]
                           + STORE_AW'(STORE_AW'(GRID_X) * addr_reg);
                op_next    = OP_SDF;
                state_next = ST_DSTART;
            end
            ST_WMUL: begin
                mul_next   = mul_p;
                op_next    = OP_AVG;
                state_next = ST_DSTART;
            end
            ST_NEXT: begin
                t2_next    = t2_reg + 24'(vs_eff);
                k_next     = k_reg + 1'b1;
                state_next = ST_CHECK;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {4'd0, cut_reg, cnt_reg, res_w_reg, res_dist_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            vs_reg      <= 16'd102;
            tr_reg      <= 16'd307;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_VOXEL_SIZE: vs_reg <= cfg_wdata;
                    REG_TRUNC:      tr_reg <= cfg_wdata;
                    default:        tr_reg <= tr_reg;
                endcase
            end
        end
        axis_reg     <= axis_next;
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        sq_reg       <= sq_next;
        n_reg        <= n_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        mul_reg      <= mul_next;
        dist_reg     <= dist_next;
        limit2_reg   <= limit2_next;
        t2_reg       <= t2_next;
        k_reg        <= k_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        sdf_reg      <= sdf_next;
        s_reg        <= s_next;
        cnt_reg      <= cnt_next;
        cut_reg      <= cut_next;
        res_dist_reg <= res_dist_next;
        res_w_reg    <= res_w_next;
        m_data_reg   <= m_data_next;
    end

    // Voxel store: distance in the upper half of each word, weight in the lower half.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store[mem_wa] <= mem_wd;
        end
        rd_data_reg <= store[addr_reg];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR || (state_reg == ST_DWAIT && op_reg == OP_AVG)))
        else $error("voxel store written outside the clear pass or an average update");

    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NEXT) |=> (k_reg == K_W'($past(k_reg) + 1'b1)))
        else $error("sample counter did not advance");

endmodule

@@ tb/tsdf_ray_integrator_tb.sv @@
// Self-checking testbench for the TSDF ray integrator: integrate and read items
// are streamed in and every result is checked against an in-bench voxel grid.
// Depends on tsdf_pkg and the RTL of tsdf_ray_integrator only.
`timescale 1ns / 100ps

module tsdf_ray_integrator_tb;
    import tsdf_pkg::*;

    localparam int GRID_X = 64;
    localparam int GRID_Y = 64;
    localparam int GRID_Z = 64;
    localparam int MAX_STEPS = 1024;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    localparam logic KIND_INTEGRATE = 1'b0;
    localparam logic KIND_READ      = 1'b1;
    localparam logic [0:0] REG_VOXEL_SIZE = 1'b0;
    localparam logic [0:0] REG_TRUNCATION = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic signed [19:0]   px, py, pz;
        logic signed [19:0]   cx, cy, cz;
        logic [STORE_AW-1:0]  idx;
    } ray_item_t;

    typedef struct packed {
        logic signed [15:0] distance;
        logic [15:0]        weight;
        logic [10:0]        updated;
        logic               cut;
    } voxel_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         cfg_wr_en;
    logic [0:0]   cfg_addr;
    logic [15:0]  cfg_wdata;

    ray_item_t     pending_items[$];
    voxel_result_t expected_voxels[$];
    int            touched_addrs[$];
    shortint       grid_dist[STORE_DEPTH];
    logic [15:0]   grid_weight[STORE_DEPTH];
    int            voxel_reg;
    int            trunc_reg;
    int            send_idle;
    int            recv_idle;
    int            errors;
    logic          took;

    tsdf_ray_integrator #(
        .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .MAX_STEPS(MAX_STEPS)
    ) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint int_root(longint n);
        longint r;
        longint t;
        r = 0;
        for (int b = 21; b >= 0; b--) begin
            t = r + (longint'(1) << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    // Walks the ray through the local grid copy, or reads one voxel.
    function automatic voxel_result_t march_ray(ray_item_t it);
        voxel_result_t r;
        longint cam[3], dlt[3], pos[3];
        longint vs, tr, sq, len, lim2, t2, k, ix, iy, iz, sdf2, s, num;
        int unsigned w;
        int addr;
        r = '0;
        if (it.kind == KIND_READ) begin
            r.distance = grid_dist[it.idx];
            r.weight = grid_weight[it.idx];
            return r;
        end
        vs = (voxel_reg == 0) ? 1 : voxel_reg;
        tr = (trunc_reg == 0) ? 1 : trunc_reg;
        cam[0] = it.cx; cam[1] = it.cy; cam[2] = it.cz;
        dlt[0] = longint'(it.px) - cam[0];
        dlt[1] = longint'(it.py) - cam[1];
        dlt[2] = longint'(it.pz) - cam[2];
        sq = dlt[0] * dlt[0] + dlt[1] * dlt[1] + dlt[2] * dlt[2];
        len = int_root(sq);
        lim2 = 2 * (len + tr);
        k = 0;
        while (1) begin
            t2 = k * vs;
            if (t2 >= lim2) break;
            if (k >= MAX_STEPS) begin
                r.cut = 1'b1;
                break;
            end
            k++;
            for (int a = 0; a < 3; a++)
                pos[a] = cam[a] + ((len > 0) ? (t2 * dlt[a]) / (2 * len) : 0);
            ix = pos[0] / vs + GRID_X / 2;
            iy = pos[1] / vs + GRID_Y / 2;
            iz = pos[2] / vs;
            if (ix < 0 || iy < 0 || iz < 0 || ix >= GRID_X || iy >= GRID_Y || iz >= GRID_Z)
                continue;
            addr = int'((ix + GRID_X * (iy + GRID_Y * iz)) & (STORE_DEPTH - 1));
            sdf2 = 2 * len - t2;
            if (sdf2 > 2 * tr) sdf2 = 2 * tr;
            if (sdf2 < -2 * tr) sdf2 = -2 * tr;
            s = (sdf2 * 8192) / tr;
            w = grid_weight[addr];
            num = longint'(w) * longint'(grid_dist[addr]) + s;
            grid_dist[addr] = shortint'(num / (longint'(w) + 1));
            grid_weight[addr] = (w < 65535) ? 16'(w + 1) : 16'hFFFF;
            if (r.updated < 11'd2047) r.updated++;
            touched_addrs.push_back(addr);
            if (touched_addrs.size() > 64) void'(touched_addrs.pop_front());
        end
        return r;
    endfunction

    // Driver: a held item stays put until it is taken.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
        if (!s_tvalid || took) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
                s_tdata <= {6'b0, pending_items[0].idx, pending_items[0].cz,
                            pending_items[0].cy, pending_items[0].cx, pending_items[0].pz,
                            pending_items[0].py, pending_items[0].px};
                s_tuser <= pending_items[0].kind;
                s_tvalid <= 1'b1;
                void'(pending_items.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Predict on acceptance, check on each returned result.
    always @(posedge aclk) begin
        ray_item_t     acc;
        voxel_result_t got;
        voxel_result_t exp_r;
        took <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) begin
            acc.kind = s_tuser[0];
            {acc.idx, acc.cz, acc.cy, acc.cx, acc.pz, acc.py, acc.px} = s_tdata[137:0];
            expected_voxels.push_back(march_ray(acc));
        end
        if (m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[42:32], m_tdata[43]};
            if (expected_voxels.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end else begin
                exp_r = expected_voxels.pop_front();
                if (got != exp_r) begin
                    $display("%0t: expected distance %0d weight %0d updated %0d cut %0d, %s",
                             $time, exp_r.distance, exp_r.weight, exp_r.updated, exp_r.cut,
                             $sformatf("got %0d %0d %0d %0d", got.distance, got.weight,
                                       got.updated, got.cut));
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [19:0] clamp20(longint v);
        if (v > 524287) return 20'sd524287;
        if (v < -524288) return -20'sd524288;
        return 20'(v);
    endfunction

    function automatic longint spread(longint m);
        return longint'($urandom_range(32'(2 * m))) - m;
    endfunction

    function automatic ray_item_t make_item(logic kind, longint px, longint py, longint pz,
                                            longint cx, longint cy, longint cz, int idx);
        ray_item_t it;
        it.kind = kind;
        it.px = clamp20(px); it.py = clamp20(py); it.pz = clamp20(pz);
        it.cx = clamp20(cx); it.cy = clamp20(cy); it.cz = clamp20(cz);
        it.idx = idx[STORE_AW-1:0];
        return it;
    endfunction

    task automatic write_reg(logic [0:0] index, int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= index;
        cfg_wdata <= value[15:0];
        if (index == REG_VOXEL_SIZE) voxel_reg = value;
        else trunc_reg = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_voxels.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    // Mostly rays that cross the grid, with reads of voxels just written.
    task automatic random_phase(int n, bit wide_noise);
        int roll;
        longint vs, cx, cy, cz;
        ray_item_t it;
        vs = (voxel_reg == 0) ? 1 : voxel_reg;
        for (int i = 0; i < n; i++) begin
            while (pending_items.size() > 2) @(posedge aclk);
            roll = $urandom_range(99);
            it = make_item(KIND_READ, spread(524288), spread(524288), spread(524288),
                           spread(524288), spread(524288), spread(524288), $urandom);
            if (roll < 40) begin
                if (touched_addrs.size() != 0 && $urandom_range(3) != 0)
                    it.idx = touched_addrs[$urandom_range(touched_addrs.size() - 1)];
            end else if (roll < 95) begin
                cx = spread(34 * vs);
                cy = spread(34 * vs);
                cz = longint'($urandom_range(32'(66 * vs))) - 2 * vs;
                it = make_item(KIND_INTEGRATE, cx + spread(3 * vs), cy + spread(3 * vs),
                               cz + spread(3 * vs), cx, cy, cz, $urandom);
            end else if (wide_noise) begin
                it.kind = KIND_INTEGRATE;
            end
            pending_items.push_back(it);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        took = 1'b0;
        errors = 0;
        voxel_reg = 102;
        trunc_reg = 307;
        send_idle = 8;
        recv_idle = 49;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            grid_dist[i] = 16384;
            grid_weight[i] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed items under the reset configuration.
        pending_items.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, STORE_DEPTH - 1));
        // Zero-length ray: every sample lands on the camera voxel.
        pending_items.push_back(make_item(KIND_INTEGRATE, 0, 0, 1000, 0, 0, 1000, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0,
                                          32 + GRID_X * (32 + GRID_Y * 9)));
        pending_items.push_back(make_item(KIND_INTEGRATE, 500, -300, 2000, 0, 0, 0, 0));
        pending_items.push_back(make_item(KIND_INTEGRATE, -2000, 1500, 3000,
                                          -1000, 500, 100, 0));
        // Starts below the grid; small negative z truncates into layer zero.
        pending_items.push_back(make_item(KIND_INTEGRATE, 0, 0, 1500, 0, 0, -2000, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 32 + GRID_X * 32));
        pending_items.push_back(make_item(KIND_INTEGRATE, 100500, 0, 0, 100000, 0, 0, 0));
        // Corner to corner: far beyond the step limit, so the ray is cut.
        pending_items.push_back(make_item(KIND_INTEGRATE, -524288, -524288, -524288,
                                          524287, 524287, 524287, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 32 + GRID_X * 32));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 0, 0, 0, 0,
                                          32 + GRID_X * (32 + GRID_Y * 9)));
        random_phase(200, 1'b0);
        wait_drained();

        send_idle = 49;
        recv_idle = 8;
        write_reg(REG_VOXEL_SIZE, 65535);
        write_reg(REG_TRUNCATION, 65535);
        random_phase(200, 1'b1);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        // Zero settings behave as one.
        write_reg(REG_VOXEL_SIZE, 0);
        write_reg(REG_TRUNCATION, 0);
        random_phase(120, 1'b0);
        wait_drained();

        write_reg(REG_VOXEL_SIZE, 512);
        write_reg(REG_TRUNCATION, 1000);
        random_phase(120, 1'b0);
        wait_drained();
        write_reg(REG_TRUNCATION, 1);
        random_phase(20, 1'b0);
        wait_drained();

        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #1_000_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tsdf_pkg.sv
src/tsdf_div.sv
src/tsdf_ray_integrator.sv
tb/tsdf_ray_integrator_tb.sv
